@@ hw/rtl/wheel_ramp_pid_controller_assert.svh @@
// Assertion macros shared by the RTL files of the wheel ramp PID controller.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef WHEEL_RAMP_PID_CONTROLLER_ASSERT_SVH
`define WHEEL_RAMP_PID_CONTROLLER_ASSERT_SVH

// A condition that must hold at every clock edge.
`define WRP_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger in one cycle that must be followed by a consequence in the next cycle.
`define WRP_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/wrp_pkg.sv @@
`default_nettype none

package wrp_pkg;

    // Number of wheels that have their own controller state.
    localparam int WHEEL_COUNT = 4;
    localparam int WHEEL_IDX_W = (WHEEL_COUNT > 1) ? $clog2(WHEEL_COUNT) : 1;

    // Field widths.
    localparam int SEL_W     = 2;
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = 17;
    localparam int DERIV_W   = 18;
    localparam int INTEG_W   = 22;
    localparam int GAIN_W    = 12;
    localparam int STEP_W    = 8;
    localparam int LIMIT_W   = 20;
    localparam int PWM_W     = 16;
    localparam int STATE_W   = INTEG_W + ERR_W;
    localparam int ACC_W     = 37;
    localparam int FRAC_BITS = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_MAX     = 3'd5;

    localparam logic [STEP_W-1:0]  RST_RAMP_STEP   = 8'd50;
    localparam logic [GAIN_W-1:0]  RST_GAIN_PROP   = 12'd128;
    localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG  = 12'd26;
    localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV  = 12'd13;
    localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 20'd10000;
    localparam logic [PWM_W-1:0]   RST_PWM_MAX     = 16'd1000;

    // Result queue behind the pipeline. It is deep enough to cover the three pipeline stages
    // plus the entry being read, so ticks can stream every cycle while the output drains.
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1) + 1;

    typedef logic [WHEEL_IDX_W-1:0] wheel_idx_t;

    typedef struct packed {
        logic [STEP_W-1:0]  ramp_step;
        logic [GAIN_W-1:0]  gain_prop;
        logic [GAIN_W-1:0]  gain_integ;
        logic [GAIN_W-1:0]  gain_deriv;
        logic [LIMIT_W-1:0] integ_limit;
        logic [PWM_W-1:0]   pwm_max;
    } cfg_t;

    // Reduce the wheel selector to a valid wheel number by repeated subtraction.
    function automatic wheel_idx_t wheel_index(input logic [SEL_W-1:0] sel);
        logic [4:0] v;
        v = {3'b000, sel};
        for (int i = 0; i < 4; i++)
        begin
            if (v >= 5'(WHEEL_COUNT))
            begin
                v = v - 5'(WHEEL_COUNT);
            end
        end
        return WHEEL_IDX_W'(v);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/wrp_ram.sv @@
`default_nettype none

// Simple dual-port RAM, one write port and one read port with registered read data.
// A read of the address being written returns the old contents.
module wrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire                                   clk,
    input  wire                                   wr_en,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire [WIDTH-1:0]                       wr_data,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/wheel_ramp_pid_controller.sv @@
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+------------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser: wheel_select; tdata: speeds
// m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: pwm_duty, ramped_speed
// cfg       | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One control tick is accepted every clock cycle while s_axis_tready is high; the per-wheel
// state memory is read at the accept edge and written back in the cycle after, and a
// forwarding register covers two ticks in a row for the same wheel. A result passes the state
// update, gain multiply and sum stages and then the result queue before it is offered.
// Reset clears the configuration to its defaults and marks every wheel's state as zero
// through per-wheel valid bits, so no clearing pass is needed.
// A stalled output fills an eight-entry result queue; s_axis_tready drops only when the
// queue plus the items in flight would exceed eight.
`include "wheel_ramp_pid_controller_assert.svh"
`default_nettype none

module wheel_ramp_pid_controller (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [15:0] target_speed, [31:16] measured_speed
    input  wire  [7:0]  s_axis_tuser,   // [1:0] wheel_select, [7:2] zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] pwm_duty, [31:16] ramped_speed
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [19:0] cfg_data
);

    localparam int SW = wrp_pkg::SPEED_W;
    localparam int EW = wrp_pkg::ERR_W;
    localparam int DW = wrp_pkg::DERIV_W;
    localparam int IW = wrp_pkg::INTEG_W;
    localparam int GW = wrp_pkg::GAIN_W;
    localparam int AW = wrp_pkg::ACC_W;
    localparam int PW = wrp_pkg::PWM_W;
    localparam int PROD_P_W = GW + 1 + EW;
    localparam int PROD_I_W = GW + 1 + IW;
    localparam int PROD_D_W = GW + 1 + DW;

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls.
    // ------------------------------------------------------------------
    wrp_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ramp_step   <= wrp_pkg::RST_RAMP_STEP;
            cfg_reg.gain_prop   <= wrp_pkg::RST_GAIN_PROP;
            cfg_reg.gain_integ  <= wrp_pkg::RST_GAIN_INTEG;
            cfg_reg.gain_deriv  <= wrp_pkg::RST_GAIN_DERIV;
            cfg_reg.integ_limit <= wrp_pkg::RST_INTEG_LIMIT;
            cfg_reg.pwm_max     <= wrp_pkg::RST_PWM_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wrp_pkg::CFG_RAMP_STEP:   cfg_reg.ramp_step   <= cfg_data[wrp_pkg::STEP_W-1:0];
                wrp_pkg::CFG_GAIN_PROP:   cfg_reg.gain_prop   <= cfg_data[GW-1:0];
                wrp_pkg::CFG_GAIN_INTEG:  cfg_reg.gain_integ  <= cfg_data[GW-1:0];
                wrp_pkg::CFG_GAIN_DERIV:  cfg_reg.gain_deriv  <= cfg_data[GW-1:0];
                wrp_pkg::CFG_INTEG_LIMIT: cfg_reg.integ_limit <= cfg_data[wrp_pkg::LIMIT_W-1:0];
                wrp_pkg::CFG_PWM_MAX:     cfg_reg.pwm_max     <= cfg_data[PW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input transfer and occupancy accounting.
    // ------------------------------------------------------------------
    logic                            s1_valid_reg;
    logic                            s2_valid_reg;
    logic                            s3_valid_reg;
    logic [wrp_pkg::OUT_CNT_W-1:0]   fifo_count_reg;
    logic [wrp_pkg::OUT_CNT_W-1:0]   total_occ;
    logic                            in_fire;
    logic                            out_fire;
    wrp_pkg::wheel_idx_t             in_wheel;

    assign total_occ = fifo_count_reg
                     + wrp_pkg::OUT_CNT_W'(s1_valid_reg)
                     + wrp_pkg::OUT_CNT_W'(s2_valid_reg)
                     + wrp_pkg::OUT_CNT_W'(s3_valid_reg);

    assign s_axis_tready = (total_occ < wrp_pkg::OUT_CNT_W'(wrp_pkg::OUT_DEPTH));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_wheel      = wrp_pkg::wheel_index(s_axis_tuser[wrp_pkg::SEL_W-1:0]);

    // ------------------------------------------------------------------
    // Stage 1: state read returns, ramp, clamp, update and write back.
    // ------------------------------------------------------------------
    wrp_pkg::wheel_idx_t         s1_wheel_reg;
    logic signed [SW-1:0]        s1_target_reg;
    logic signed [SW-1:0]        s1_meas_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_wheel_reg  <= in_wheel;
            s1_target_reg <= $signed(s_axis_tdata[SW-1:0]);
            s1_meas_reg   <= $signed(s_axis_tdata[2*SW-1:SW]);
        end
    end

    logic [wrp_pkg::STATE_W-1:0]     ram_rd_data;
    logic [wrp_pkg::STATE_W-1:0]     ram_wr_data;
    logic                            ram_wr_en;
    logic [wrp_pkg::WHEEL_COUNT-1:0] valid_bits_reg;
    logic                            fwd_valid_reg;
    wrp_pkg::wheel_idx_t             fwd_addr_reg;
    logic [wrp_pkg::STATE_W-1:0]     fwd_data_reg;

    wrp_ram #(
        .WIDTH (wrp_pkg::STATE_W),
        .DEPTH (wrp_pkg::WHEEL_COUNT)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (s1_wheel_reg),
        .wr_data (ram_wr_data),
        .rd_addr (in_wheel),
        .rd_data (ram_rd_data)
    );

    logic [wrp_pkg::STATE_W-1:0] s1_state;
    logic signed [IW-1:0]        s1_integ_old;
    logic signed [EW-1:0]        s1_last_err;
    logic signed [EW-1:0]        s1_diff;
    logic signed [EW-1:0]        s1_step;
    logic signed [EW-1:0]        s1_err;
    logic signed [SW-1:0]        s1_ramped;
    logic signed [IW-1:0]        s1_lim;
    logic signed [IW-1:0]        s1_integ_clamped;
    logic signed [IW-1:0]        s1_integ_new;
    logic signed [DW-1:0]        s1_deriv;

    always_comb
    begin
        // The previous tick's write reaches the memory at the edge where this tick read it,
        // so a tick that follows its own wheel takes the forwarded value.
        if (fwd_valid_reg && (fwd_addr_reg == s1_wheel_reg))
        begin
            s1_state = fwd_data_reg;
        end
        else if (valid_bits_reg[s1_wheel_reg])
        begin
            s1_state = ram_rd_data;
        end
        else
        begin
            s1_state = '0;
        end

        s1_integ_old = $signed(s1_state[IW-1:0]);
        s1_last_err  = $signed(s1_state[wrp_pkg::STATE_W-1:IW]);

        // The error is the ramp step toward the target, or the full difference when that
        // lies within the step.
        s1_diff = EW'(s1_target_reg) - EW'(s1_meas_reg);
        s1_step = $signed({{(EW - wrp_pkg::STEP_W){1'b0}}, cfg_reg.ramp_step});
        if (s1_diff > s1_step)
        begin
            s1_err = s1_step;
        end
        else if (s1_diff < -s1_step)
        begin
            s1_err = -s1_step;
        end
        else
        begin
            s1_err = s1_diff;
        end
        s1_ramped = s1_meas_reg + s1_err[SW-1:0];

        s1_lim = $signed({{(IW - wrp_pkg::LIMIT_W){1'b0}}, cfg_reg.integ_limit});
        if (s1_integ_old > s1_lim)
        begin
            s1_integ_clamped = s1_lim;
        end
        else if (s1_integ_old < -s1_lim)
        begin
            s1_integ_clamped = -s1_lim;
        end
        else
        begin
            s1_integ_clamped = s1_integ_old;
        end

        s1_integ_new = s1_integ_clamped + IW'(s1_err);
        s1_deriv     = DW'(s1_err) - DW'(s1_last_err);
    end

    assign ram_wr_en   = s1_valid_reg;
    assign ram_wr_data = {s1_err, s1_integ_new};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg <= '0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= ram_wr_en;
            if (ram_wr_en)
            begin
                valid_bits_reg[s1_wheel_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_wr_en)
        begin
            fwd_addr_reg <= s1_wheel_reg;
            fwd_data_reg <= ram_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: gain products.
    // ------------------------------------------------------------------
    logic signed [EW-1:0]  s2_err_reg;
    logic signed [IW-1:0]  s2_integ_reg;
    logic signed [DW-1:0]  s2_deriv_reg;
    logic signed [SW-1:0]  s2_ramped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_err_reg    <= s1_err;
            s2_integ_reg  <= s1_integ_new;
            s2_deriv_reg  <= s1_deriv;
            s2_ramped_reg <= s1_ramped;
        end
    end

    logic signed [PROD_P_W-1:0] s2_prod_p;
    logic signed [PROD_I_W-1:0] s2_prod_i;
    logic signed [PROD_D_W-1:0] s2_prod_d;

    assign s2_prod_p = $signed({1'b0, cfg_reg.gain_prop})  * s2_err_reg;
    assign s2_prod_i = $signed({1'b0, cfg_reg.gain_integ}) * s2_integ_reg;
    assign s2_prod_d = $signed({1'b0, cfg_reg.gain_deriv}) * s2_deriv_reg;

    // ------------------------------------------------------------------
    // Stage 3: sum, scale and saturate.
    // ------------------------------------------------------------------
    logic signed [PROD_P_W-1:0] s3_prod_p_reg;
    logic signed [PROD_I_W-1:0] s3_prod_i_reg;
    logic signed [PROD_D_W-1:0] s3_prod_d_reg;
    logic signed [SW-1:0]       s3_ramped_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_prod_p_reg <= s2_prod_p;
            s3_prod_i_reg <= s2_prod_i;
            s3_prod_d_reg <= s2_prod_d;
            s3_ramped_reg <= s2_ramped_reg;
        end
    end

    logic signed [AW-1:0] s3_acc;
    logic [PW-1:0]        s3_duty;

    always_comb
    begin
        s3_acc = AW'(s3_prod_p_reg) + AW'(s3_prod_i_reg) + AW'(s3_prod_d_reg);
        // A negative sum scales to zero or below either way, so only the sign matters there.
        if (s3_acc[AW-1])
        begin
            s3_duty = '0;
        end
        else if (s3_acc[AW-2:wrp_pkg::FRAC_BITS]
                 > {{(AW - 1 - wrp_pkg::FRAC_BITS - PW){1'b0}}, cfg_reg.pwm_max})
        begin
            s3_duty = cfg_reg.pwm_max;
        end
        else
        begin
            s3_duty = s3_acc[wrp_pkg::FRAC_BITS+PW-1:wrp_pkg::FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Result queue. The accept rule above keeps it from overflowing, so the
    // pipeline never has to stall.
    // ------------------------------------------------------------------
    logic [31:0]                   fifo_mem_reg [wrp_pkg::OUT_DEPTH];
    logic [wrp_pkg::OUT_PTR_W-1:0] wr_ptr_reg;
    logic [wrp_pkg::OUT_PTR_W-1:0] rd_ptr_reg;

    assign m_axis_tvalid = (fifo_count_reg != '0);
    assign m_axis_tdata  = fifo_mem_reg[rd_ptr_reg];
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (s3_valid_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (s3_valid_reg && !out_fire)
            begin
                fifo_count_reg <= fifo_count_reg + 1'b1;
            end
            else if (!s3_valid_reg && out_fire)
            begin
                fifo_count_reg <= fifo_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            fifo_mem_reg[wr_ptr_reg] <= {s3_ramped_reg, s3_duty};
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `WRP_ASSERT(a_occupancy_bound,
        total_occ <= wrp_pkg::OUT_CNT_W'(wrp_pkg::OUT_DEPTH),
        "items in flight and queued exceed the result queue depth")

    `WRP_ASSERT(a_no_push_when_full,
        !(s3_valid_reg && !out_fire && fifo_count_reg == wrp_pkg::OUT_CNT_W'(wrp_pkg::OUT_DEPTH)),
        "result pushed into a full queue")

    `WRP_ASSERT(a_duty_in_range,
        !m_axis_tvalid || (m_axis_tdata[PW-1:0] <= cfg_reg.pwm_max),
        "pwm_duty above pwm_max")

    `WRP_ASSERT_NEXT(a_accept_enters_pipe, in_fire, s1_valid_reg,
        "accepted tick did not enter the state update stage")

    `WRP_ASSERT_NEXT(a_write_marks_valid, ram_wr_en,
        valid_bits_reg[$past(s1_wheel_reg)] && fwd_valid_reg,
        "state write did not mark the wheel valid or load the forwarding register")

endmodule

`default_nettype wire
